/* rtl/core/assert_macros.svh */
// Assertion macros for the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/hidrp_pkg.sv */
// Shared types and constants of the HID report descriptor parser.
`default_nettype none
package hidrp_pkg;
    localparam int STACK_DEPTH_DEF = 8;
    localparam int MAX_USAGES_DEF  = 16;

    localparam logic [7:0] LONG_HDR  = 8'hFE;
    localparam logic [7:0] SIZE_MASK = 8'h03;
    localparam logic [7:0] TYPE_MASK = 8'h0C;
    localparam logic [7:0] TAG_MASK  = 8'hF0;

    localparam logic [2:0] RK_USAGE = 3'd0;
    localparam logic [2:0] RK_RANGE = 3'd1;
    localparam logic [2:0] RK_COLL  = 3'd2;
    localparam logic [2:0] RK_ERROR = 3'd3;
    localparam logic [2:0] RK_END   = 3'd4;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_TRUNC    = 4'd1;
    localparam logic [3:0] ST_SIZE     = 4'd2;
    localparam logic [3:0] ST_COLL     = 4'd3;
    localparam logic [3:0] ST_STRAY    = 4'd4;
    localparam logic [3:0] ST_DELIM    = 4'd5;
    localparam logic [3:0] ST_STACK    = 4'd6;
    localparam logic [3:0] ST_USAGE    = 4'd7;
    localparam logic [3:0] ST_UNCLOSED = 4'd8;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // take a new byte
        logic       emit_one;  // drain one record from the pending list
    } hidrp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       has_rec;   // records remain to be drained
        logic       last_rec;  // record on offer is the last of its byte
    } hidrp_sts_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [1:0]  report_kind;
        logic [7:0]  report_number;
        logic [31:0] field_count;
        logic [31:0] field_bits;
        logic [31:0] field_flags;
        logic [31:0] usage_value;
        logic [31:0] usage_upper;
        logic [31:0] collection_kind;
        logic [3:0]  status_code;
        logic        last_record;
    } hidrp_rec_t;
endpackage
`default_nettype wire

/* rtl/core/hidrp_ctrl.sv */
// Controller: accepts a byte, then drains its records one per cycle while out_ready is high.
`default_nettype none
`include "assert_macros.svh"
module hidrp_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire                    out_ready,
    output hidrp_pkg::hidrp_cmd_t  cmd,
    input  hidrp_pkg::hidrp_sts_t  sts
);
    import hidrp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROC  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.load     = 1'b0;
        cmd.emit_one = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                state_next = sts.has_rec ? S_DRAIN : S_IDLE;
            end
            S_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_one = 1'b1;
                    if (sts.last_rec)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `ASSERT_NEVER(a_no_ready_in_drain, clk, rst_n, in_ready && out_valid,
        "input taken while draining")
    `ASSERT_IMPL(a_load_leads_proc, clk, rst_n, cmd.load |=> (state_reg == S_PROC),
        "load did not start processing")
    `ASSERT_NEVER(a_bad_state, clk, rst_n, state_reg == 2'd3, "illegal state")
endmodule
`default_nettype wire

/* rtl/core/hidrp_dp.sv */
// Datapath: item assembly, global stack, local usages and record generation.
`default_nettype none
module hidrp_dp #(
    parameter int STACK_DEPTH = hidrp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_USAGES  = hidrp_pkg::MAX_USAGES_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire  [7:0]             desc_byte,
    input  wire                    final_byte,
    input  hidrp_pkg::hidrp_cmd_t  cmd,
    output hidrp_pkg::hidrp_sts_t  sts,
    output hidrp_pkg::hidrp_rec_t  rec
);
    import hidrp_pkg::*;

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int UW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
    localparam int FW = $clog2(MAX_USAGES + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SDATA  = 3'd1;
    localparam logic [2:0] PH_LSIZE  = 3'd2;
    localparam logic [2:0] PH_LTAG   = 3'd3;
    localparam logic [2:0] PH_LDATA  = 3'd4;
    localparam logic [1:0] DL_CLOSED = 2'd0;
    localparam logic [1:0] DL_FIRST  = 2'd1;
    localparam logic [1:0] DL_OTHERS = 2'd2;

    localparam logic [1:0] PK_NONE  = 2'd0;
    localparam logic [1:0] PK_LIST  = 2'd1;
    localparam logic [1:0] PK_ONE   = 2'd2;

    logic [2:0]  phase_reg;
    logic [7:0]  left_reg;
    logic [7:0]  hdr_reg;
    logic [31:0] acc_reg;
    logic [15:0] page_st [STACK_DEPTH];
    logic [31:0] size_st [STACK_DEPTH];
    logic [7:0]  id_st   [STACK_DEPTH];
    logic [31:0] cnt_st  [STACK_DEPTH];
    logic [SW-1:0] top_reg;
    logic [31:0] use_st [MAX_USAGES];
    logic [FW-1:0] fill_reg;
    logic [31:0] rlo_reg, rhi_reg;
    logic [1:0]  dl_reg;
    logic [15:0] depth_reg;
    logic        err_reg;
    logic        fin_reg;

    // pending record generation: kind of pending work, a template record and a list index
    logic [1:0]    pk_reg;
    hidrp_rec_t    tmpl_reg;
    logic          end_reg;    // an end/trunc record follows the list
    hidrp_rec_t    end_rec_reg;
    logic [FW-1:0] idx_reg;
    logic [FW-1:0] list_n_reg;
    logic          clr_reg;    // clear locals after drain

    // item decode happens on load from the incoming byte
    logic        done;
    logic [2:0]  ph_n;
    logic [7:0]  left_n, hdr_n;
    logic [31:0] acc_n;
    logic [1:0]  isz;
    logic [2:0]  ssz;

    function automatic logic [2:0] short_size(input logic [7:0] h);
        return ((h & SIZE_MASK) == 8'd3) ? 3'd4 : {1'b0, h[1:0]};
    endfunction

    always_comb
    begin
        done   = 1'b0;
        ph_n   = phase_reg;
        left_n = left_reg;
        hdr_n  = hdr_reg;
        acc_n  = acc_reg;
        isz    = 2'd0;
        ssz    = short_size(hdr_reg);
        unique case (phase_reg)
            PH_HEADER:
            begin
                hdr_n = desc_byte;
                acc_n = 32'd0;
                if (desc_byte == LONG_HDR)
                    ph_n = PH_LSIZE;
                else if (short_size(desc_byte) == 3'd0)
                    done = 1'b1;
                else
                begin
                    left_n = {5'd0, short_size(desc_byte)};
                    ph_n   = PH_SDATA;
                end
            end
            PH_SDATA:
            begin
                isz = 2'(ssz - left_reg[2:0]);
                acc_n = acc_reg | ({24'd0, desc_byte} << {isz, 3'd0});
                if (left_reg <= 8'd1)
                begin
                    left_n = 8'd0;
                    ph_n   = PH_HEADER;
                    done   = 1'b1;
                end
                else
                    left_n = left_reg - 8'd1;
            end
            PH_LSIZE:
            begin
                left_n = desc_byte;
                ph_n   = PH_LTAG;
            end
            PH_LTAG:  ph_n = (left_reg == 8'd0) ? PH_HEADER : PH_LDATA;
            PH_LDATA:
            begin
                if (left_reg <= 8'd1)
                begin
                    left_n = 8'd0;
                    ph_n   = PH_HEADER;
                end
                else
                    left_n = left_reg - 8'd1;
            end
            default: ph_n = PH_HEADER;
        endcase
    end

    // item execution (decoded item, not yet registered, in hdr_n/acc_n)
    logic [1:0]  ityp;
    logic [3:0]  itag;
    logic [2:0]  isize;
    logic [31:0] d;
    logic [31:0] uval;
    logic        raise;
    logic [3:0]  ecode;
    logic        push_op, pop_op, set_page, set_size, set_id, set_cnt;
    logic        add_use, set_lo, set_hi, clr_loc;
    logic [1:0]  dl_n;
    logic [15:0] depth_n;
    logic [1:0]  pk_n;
    hidrp_rec_t  tmpl_n;

    always_comb
    begin
        ityp  = hdr_n[3:2];
        itag  = hdr_n[7:4];
        isize = short_size(hdr_n);
        d     = acc_n;
        uval  = (isize == 3'd4) ? d : {page_st[top_reg], d[15:0]};
        raise = 1'b0;
        ecode = ST_OK;
        push_op = 1'b0; pop_op = 1'b0; set_page = 1'b0; set_size = 1'b0;
        set_id = 1'b0; set_cnt = 1'b0; add_use = 1'b0; set_lo = 1'b0; set_hi = 1'b0;
        clr_loc = 1'b0;
        dl_n    = dl_reg;
        depth_n = depth_reg;
        pk_n    = PK_NONE;
        tmpl_n  = '0;
        tmpl_n.report_number = id_st[top_reg];
        tmpl_n.field_count   = cnt_st[top_reg];
        tmpl_n.field_bits    = size_st[top_reg];
        tmpl_n.field_flags   = d;
        if (done)
        begin
            unique case (ityp)
                2'd0:
                begin
                    clr_loc = 1'b1;
                    if (itag == 4'd8 || itag == 4'd9 || itag == 4'd11)
                    begin
                        tmpl_n.report_kind = (itag == 4'd8) ? 2'd0 :
                                             (itag == 4'd9) ? 2'd1 : 2'd2;
                        if (fill_reg != '0)
                        begin
                            pk_n = PK_LIST;
                            tmpl_n.record_kind = RK_USAGE;
                        end
                        else if (rlo_reg != 0 || rhi_reg != 0 || !d[0])
                        begin
                            pk_n = PK_ONE;
                            tmpl_n.record_kind = RK_RANGE;
                            tmpl_n.usage_value = rlo_reg;
                            tmpl_n.usage_upper = rhi_reg;
                        end
                    end
                    else if (itag == 4'd10)
                    begin
                        if (depth_reg == 16'd0)
                        begin
                            if (fill_reg != FW'(1))
                            begin
                                raise = 1'b1; ecode = ST_COLL; clr_loc = 1'b0;
                            end
                            else
                            begin
                                pk_n = PK_ONE;
                                tmpl_n = '0;
                                tmpl_n.record_kind     = RK_COLL;
                                tmpl_n.usage_value     = use_st[0];
                                tmpl_n.collection_kind = d;
                            end
                        end
                        if (!raise && depth_reg != 16'hFFFF)
                            depth_n = depth_reg + 16'd1;
                    end
                    else if (itag == 4'd12)
                    begin
                        if (depth_reg == 16'd0)
                        begin
                            raise = 1'b1; ecode = ST_STRAY; clr_loc = 1'b0;
                        end
                        else
                            depth_n = depth_reg - 16'd1;
                    end
                end
                2'd1:
                begin
                    priority case (itag)
                        4'd0: if (isize > 3'd2) begin raise = 1'b1; ecode = ST_SIZE; end
                              else set_page = 1'b1;
                        4'd7: set_size = 1'b1;
                        4'd8: if (isize > 3'd1) begin raise = 1'b1; ecode = ST_SIZE; end
                              else set_id = 1'b1;
                        4'd9: set_cnt = 1'b1;
                        4'd10: if ({1'b0, top_reg} + 1 >= STACK_DEPTH)
                               begin raise = 1'b1; ecode = ST_STACK; end
                               else push_op = 1'b1;
                        4'd11: if (top_reg == '0) begin raise = 1'b1; ecode = ST_STACK; end
                               else pop_op = 1'b1;
                        default: ;
                    endcase
                end
                2'd2:
                begin
                    priority case (itag)
                        4'd0:
                        begin
                            if (dl_reg != DL_OTHERS)
                            begin
                                if (isize == 3'd0) begin raise = 1'b1; ecode = ST_SIZE; end
                                else if (fill_reg >= FW'(MAX_USAGES))
                                begin raise = 1'b1; ecode = ST_USAGE; end
                                else add_use = 1'b1;
                            end
                            if (!raise && dl_reg == DL_FIRST)
                                dl_n = DL_OTHERS;
                        end
                        4'd1: if (isize == 3'd0) begin raise = 1'b1; ecode = ST_SIZE; end
                              else set_lo = 1'b1;
                        4'd2: if (isize == 3'd0) begin raise = 1'b1; ecode = ST_SIZE; end
                              else set_hi = 1'b1;
                        4'd10:
                        begin
                            if (d == 32'd1)
                            begin
                                if (dl_reg != DL_CLOSED) begin raise = 1'b1; ecode = ST_DELIM; end
                                else dl_n = DL_FIRST;
                            end
                            else if (d == 32'd0)
                            begin
                                if (dl_reg == DL_CLOSED) begin raise = 1'b1; ecode = ST_DELIM; end
                                else dl_n = DL_CLOSED;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (raise)
        begin
            pk_n = PK_ONE;
            tmpl_n = '0;
            tmpl_n.record_kind = RK_ERROR;
            tmpl_n.status_code = ecode;
        end
    end

    // end-of-descriptor record
    logic       want_end;
    hidrp_rec_t end_n;
    always_comb
    begin
        want_end = final_byte && !raise;
        end_n = '0;
        if (ph_n != PH_HEADER)
        begin
            end_n.record_kind = RK_ERROR;
            end_n.status_code = ST_TRUNC;
        end
        else
        begin
            end_n.record_kind = RK_END;
            end_n.status_code = (depth_n != 16'd0) ? ST_UNCLOSED : ST_OK;
        end
    end

    // drain side
    logic list_more;
    always_comb
    begin
        list_more = (pk_reg == PK_LIST) && (idx_reg + FW'(1) < list_n_reg);
        rec = tmpl_reg;
        if (pk_reg == PK_LIST)
            rec.usage_value = use_st[idx_reg[UW-1:0]];
        rec.last_record = 1'b0;
        if (pk_reg == PK_NONE)
            rec = end_rec_reg;
        if ((pk_reg == PK_NONE) || (!list_more && !end_reg))
            rec.last_record = 1'b1;
        sts.has_rec  = (pk_reg != PK_NONE) || end_reg;
        sts.last_rec = rec.last_record;
    end

    logic do_exec;
    assign do_exec = cmd.load && !err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            left_reg  <= 8'd0;
            hdr_reg   <= 8'd0;
            acc_reg   <= 32'd0;
            top_reg   <= '0;
            fill_reg  <= '0;
            rlo_reg   <= 32'd0;
            rhi_reg   <= 32'd0;
            dl_reg    <= DL_CLOSED;
            depth_reg <= 16'd0;
            err_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            pk_reg    <= PK_NONE;
            end_reg   <= 1'b0;
            idx_reg   <= '0;
            list_n_reg <= '0;
            clr_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            fin_reg <= final_byte;
            idx_reg <= '0;
            if (do_exec)
            begin
                phase_reg <= ph_n;
                left_reg  <= left_n;
                hdr_reg   <= hdr_n;
                acc_reg   <= acc_n;
                pk_reg    <= pk_n;
                end_reg   <= want_end;
                list_n_reg <= fill_reg;
                if (push_op) top_reg <= top_reg + SW'(1);
                if (pop_op)  top_reg <= top_reg - SW'(1);
                if (add_use) fill_reg <= fill_reg + FW'(1);
                if (set_lo)  rlo_reg <= uval;
                if (set_hi)  rhi_reg <= uval;
                clr_reg   <= clr_loc;
                dl_reg    <= dl_n;
                depth_reg <= depth_n;
                if (raise) err_reg <= 1'b1;
            end
            else
            begin
                pk_reg  <= PK_NONE;
                end_reg <= 1'b0;
                clr_reg <= 1'b0;
            end
        end
        else if (cmd.emit_one || (!sts.has_rec))
        begin
            // advance drain; after last record apply deferred clears/reset
            if (cmd.emit_one && list_more)
                idx_reg <= idx_reg + FW'(1);
            else if (cmd.emit_one && pk_reg != PK_NONE)
                pk_reg <= PK_NONE;
            else if (cmd.emit_one)
                end_reg <= 1'b0;
            if (!sts.has_rec || (cmd.emit_one && rec.last_record))
            begin
                if (clr_reg)
                begin
                    fill_reg <= '0;
                    rlo_reg  <= 32'd0;
                    rhi_reg  <= 32'd0;
                    clr_reg  <= 1'b0;
                end
                if (fin_reg)
                begin
                    phase_reg <= PH_HEADER;
                    left_reg  <= 8'd0;
                    hdr_reg   <= 8'd0;
                    acc_reg   <= 32'd0;
                    top_reg   <= '0;
                    fill_reg  <= '0;
                    rlo_reg   <= 32'd0;
                    rhi_reg   <= 32'd0;
                    dl_reg    <= DL_CLOSED;
                    depth_reg <= 16'd0;
                    err_reg   <= 1'b0;
                    fin_reg   <= 1'b0;
                end
            end
        end
    end

    // payload stores
    always_ff @(posedge clk)
    begin
        if (do_exec)
        begin
            tmpl_reg    <= tmpl_n;
            end_rec_reg <= end_n;
            if (set_page) page_st[top_reg] <= d[15:0];
            if (set_size) size_st[top_reg] <= d;
            if (set_id)   id_st[top_reg]   <= d[7:0];
            if (set_cnt)  cnt_st[top_reg]  <= d;
            if (push_op)
            begin
                page_st[top_reg + SW'(1)] <= page_st[top_reg];
                size_st[top_reg + SW'(1)] <= size_st[top_reg];
                id_st[top_reg + SW'(1)]   <= id_st[top_reg];
                cnt_st[top_reg + SW'(1)]  <= cnt_st[top_reg];
            end
            if (add_use) use_st[fill_reg[UW-1:0]] <= uval;
        end
        if (!rst_n || (!cmd.load && fin_reg && (!sts.has_rec ||
            (cmd.emit_one && rec.last_record))))
        begin
            page_st[0] <= 16'd0;
            size_st[0] <= 32'd0;
            id_st[0]   <= 8'd0;
            cnt_st[0]  <= 32'd0;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/hid_report_descriptor_parser.sv */
// Top level of the HID report descriptor parser.
// Usage:
//  - s_axis carries one descriptor byte per beat: tdata = desc_byte, tlast = final_byte.
//  - m_axis carries result records; tlast marks the last record of a byte.
//  - Each byte is accepted and then decoded; a byte with records then holds
//    off the input until they drain, one record per cycle while m_axis_tready is high.
//    Main items drain the usage list one entry per cycle from the usage store.
//  - A stalled receiver holds the current record; no input is taken meanwhile.
//  - Reset clears the parse state and global stack entry 0; the last byte of a
//    descriptor also returns all state to reset after its records drain.
//  - After an error record, bytes up to tlast are taken and give no records.
//  m_axis_tdata fields, low bit up: record_kind[2:0], report_kind[1:0],
//  report_number[7:0], field_count, field_bits, field_flags, usage_value,
//  usage_upper, collection_kind, status_code[3:0], zero fill to 216 bits.
`default_nettype none
module hid_report_descriptor_parser #(
    parameter int STACK_DEPTH = hidrp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_USAGES  = hidrp_pkg::MAX_USAGES_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // desc_byte[7:0]
    input  wire          s_axis_tlast,   // final_byte
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [215:0] m_axis_tdata,   // see field list above
    output logic         m_axis_tlast    // last_record
);
    import hidrp_pkg::*;

    hidrp_cmd_t cmd;
    hidrp_sts_t sts;
    hidrp_rec_t rec;

    hidrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    hidrp_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_USAGES  (MAX_USAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .cmd        (cmd),
        .sts        (sts),
        .rec        (rec)
    );

    assign m_axis_tdata = {7'd0, rec.status_code, rec.collection_kind, rec.usage_upper,
                           rec.usage_value, rec.field_flags, rec.field_bits,
                           rec.field_count, rec.report_number, rec.report_kind,
                           rec.record_kind};
    assign m_axis_tlast = rec.last_record;
endmodule
`default_nettype wire

/* tb/sv/hid_report_descriptor_parser_chk.sv */
// Checker for the HID report descriptor parser: byte-level predictor and record compare.
`default_nettype none
module hid_report_descriptor_parser_chk
    import hidrp_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,
    input  wire          s_axis_tlast,
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire  [215:0] m_axis_tdata,
    input  wire          m_axis_tlast,
    output int           fail_count,
    output int           records_pending
);
    localparam int SDEPTH = STACK_DEPTH_DEF;
    localparam int NUSE   = MAX_USAGES_DEF;

    typedef enum logic [2:0] {PH_HDR, PH_SDATA, PH_LSIZE, PH_LTAG, PH_LDATA} phase_t;
    typedef enum logic [1:0] {DL_CLOSED, DL_FIRST, DL_OTHERS} delim_t;

    // item types and tags
    localparam logic [1:0] TY_MAIN = 2'd0, TY_GLOBAL = 2'd1, TY_LOCAL = 2'd2;
    localparam logic [3:0] MT_INPUT = 4'd8, MT_OUTPUT = 4'd9, MT_COLL = 4'd10,
                           MT_FEATURE = 4'd11, MT_END = 4'd12;
    localparam logic [3:0] GT_PAGE = 4'd0, GT_SIZE = 4'd7, GT_ID = 4'd8, GT_COUNT = 4'd9,
                           GT_PUSH = 4'd10, GT_POP = 4'd11;
    localparam logic [3:0] LT_USAGE = 4'd0, LT_MIN = 4'd1, LT_MAX = 4'd2, LT_DELIM = 4'd10;

    phase_t      phase;
    delim_t      delim;
    logic [7:0]  left_cnt, hdr;
    logic [31:0] acc;
    logic [15:0] pg_stk [SDEPTH];
    logic [31:0] sz_stk [SDEPTH];
    logic [7:0]  id_stk [SDEPTH];
    logic [31:0] ct_stk [SDEPTH];
    int          top;
    logic [31:0] usages [NUSE];
    int          ufill;
    logic [31:0] rlo, rhi;
    logic [15:0] depth;
    bit          err;

    hidrp_rec_t  expected_recs[$];

    assign records_pending = expected_recs.size();

    function automatic void clear_parse();
        phase = PH_HDR; left_cnt = 0; hdr = 0; acc = 0;
        for (int i = 0; i < SDEPTH; i++)
        begin
            pg_stk[i] = 0; sz_stk[i] = 0; id_stk[i] = 0; ct_stk[i] = 0;
        end
        for (int i = 0; i < NUSE; i++)
            usages[i] = 0;
        top = 0; ufill = 0; rlo = 0; rhi = 0;
        delim = DL_CLOSED; depth = 0; err = 0;
    endfunction

    function automatic void add_rec(logic [2:0] kind, logic [1:0] rk, logic [7:0] rn,
                                    logic [31:0] cnt, logic [31:0] bits, logic [31:0] flags,
                                    logic [31:0] uv, logic [31:0] uu, logic [31:0] ck,
                                    logic [3:0] st);
        hidrp_rec_t r;
        r.record_kind = kind; r.report_kind = rk; r.report_number = rn;
        r.field_count = cnt; r.field_bits = bits; r.field_flags = flags;
        r.usage_value = uv; r.usage_upper = uu; r.collection_kind = ck;
        r.status_code = st; r.last_record = 1'b0;
        expected_recs = {expected_recs, r};
    endfunction

    function automatic void flag_error(logic [3:0] st);
        add_rec(RK_ERROR, 0, 0, 0, 0, 0, 0, 0, 0, st);
        err = 1;
    endfunction

    function automatic int data_len(logic [7:0] h);
        return (h[1:0] == 2'd3) ? 4 : int'(h[1:0]);
    endfunction

    // usage from data bytes; 4-byte form carries its own page
    function automatic bit make_usage(output logic [31:0] u);
        int s;
        s = data_len(hdr);
        u = 0;
        if (s == 0)
        begin
            flag_error(ST_SIZE);
            return 0;
        end
        u = (s == 4) ? acc : {pg_stk[top], acc[15:0]};
        return 1;
    endfunction

    function automatic void do_main(logic [3:0] tag);
        logic [1:0] rk;
        if (tag == MT_INPUT || tag == MT_OUTPUT || tag == MT_FEATURE)
        begin
            rk = (tag == MT_INPUT) ? 2'd0 : (tag == MT_OUTPUT) ? 2'd1 : 2'd2;
            // constant field with no usages is padding
            if (ufill != 0 || rlo != 0 || rhi != 0 || !acc[0])
            begin
                if (ufill != 0)
                    for (int i = 0; i < ufill; i++)
                        add_rec(RK_USAGE, rk, id_stk[top], ct_stk[top], sz_stk[top], acc,
                                usages[i], 0, 0, ST_OK);
                else
                    add_rec(RK_RANGE, rk, id_stk[top], ct_stk[top], sz_stk[top], acc,
                            rlo, rhi, 0, ST_OK);
            end
        end
        else if (tag == MT_COLL)
        begin
            if (depth == 0)
            begin
                if (ufill != 1)
                begin
                    flag_error(ST_COLL);
                    return;
                end
                add_rec(RK_COLL, 0, 0, 0, 0, 0, usages[0], 0, acc, ST_OK);
            end
            if (depth != 16'hFFFF)
                depth++;
        end
        else if (tag == MT_END)
        begin
            if (depth == 0)
            begin
                flag_error(ST_STRAY);
                return;
            end
            depth--;
        end
        ufill = 0; rlo = 0; rhi = 0;
    endfunction

    function automatic void do_global(logic [3:0] tag);
        int s;
        s = data_len(hdr);
        case (tag)
            GT_PAGE:
                if (s > 2) flag_error(ST_SIZE);
                else pg_stk[top] = acc[15:0];
            GT_SIZE:  sz_stk[top] = acc;
            GT_ID:
                if (s > 1) flag_error(ST_SIZE);
                else id_stk[top] = acc[7:0];
            GT_COUNT: ct_stk[top] = acc;
            GT_PUSH:
                if (top + 1 >= SDEPTH) flag_error(ST_STACK);
                else
                begin
                    pg_stk[top+1] = pg_stk[top]; sz_stk[top+1] = sz_stk[top];
                    id_stk[top+1] = id_stk[top]; ct_stk[top+1] = ct_stk[top];
                    top++;
                end
            GT_POP:
                if (top == 0) flag_error(ST_STACK);
                else top--;
            default: ;
        endcase
    endfunction

    function automatic void do_local(logic [3:0] tag);
        logic [31:0] u;
        case (tag)
            LT_USAGE:
            begin
                // usages after the first in a delimiter set are alternates and skipped
                if (delim != DL_OTHERS)
                begin
                    if (!make_usage(u)) return;
                    if (ufill >= NUSE)
                    begin
                        flag_error(ST_USAGE);
                        return;
                    end
                    usages[ufill] = u;
                    ufill++;
                end
                if (delim == DL_FIRST)
                    delim = DL_OTHERS;
            end
            LT_MIN: if (make_usage(u)) rlo = u;
            LT_MAX: if (make_usage(u)) rhi = u;
            LT_DELIM:
                if (acc == 1)
                begin
                    if (delim != DL_CLOSED) flag_error(ST_DELIM);
                    else delim = DL_FIRST;
                end
                else if (acc == 0)
                begin
                    if (delim == DL_CLOSED) flag_error(ST_DELIM);
                    else delim = DL_CLOSED;
                end
            default: ;
        endcase
    endfunction

    function automatic void take_byte(logic [7:0] b, logic fin);
        int  n0;
        int  idx;
        bit  done;
        n0 = expected_recs.size();
        done = 0;
        if (!err)
        begin
            case (phase)
                PH_HDR:
                begin
                    hdr = b; acc = 0;
                    if (b == LONG_HDR) phase = PH_LSIZE;
                    else if (data_len(b) == 0) done = 1;
                    else
                    begin
                        left_cnt = 8'(data_len(b));
                        phase = PH_SDATA;
                    end
                end
                PH_SDATA:
                begin
                    idx = (data_len(hdr) - int'(left_cnt)) & 3;
                    acc |= 32'(b) << (8 * idx);
                    if (left_cnt <= 1)
                    begin
                        left_cnt = 0; phase = PH_HDR; done = 1;
                    end
                    else left_cnt--;
                end
                PH_LSIZE:
                begin
                    left_cnt = b; phase = PH_LTAG;
                end
                PH_LTAG: phase = (left_cnt == 0) ? PH_HDR : PH_LDATA;
                default:
                    if (left_cnt <= 1)
                    begin
                        left_cnt = 0; phase = PH_HDR;
                    end
                    else left_cnt--;
            endcase
            if (done)
                case (hdr[3:2])
                    TY_MAIN:   do_main(hdr[7:4]);
                    TY_GLOBAL: do_global(hdr[7:4]);
                    TY_LOCAL:  do_local(hdr[7:4]);
                    default: ;
                endcase
            if (fin && !err)
            begin
                if (phase != PH_HDR) flag_error(ST_TRUNC);
                else add_rec(RK_END, 0, 0, 0, 0, 0, 0, 0, 0,
                             depth != 0 ? ST_UNCLOSED : ST_OK);
            end
        end
        if (expected_recs.size() > n0)
            expected_recs[expected_recs.size()-1].last_record = 1'b1;
        if (fin)
            clear_parse();
    endfunction

    task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        clear_parse();
    end

    always @(posedge clk)
    begin
        hidrp_rec_t e;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            take_byte(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_recs.size() == 0)
            begin
                $error("record beat with nothing expected: %0h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                e = expected_recs.pop_front();
                cmp("record_kind",     e.record_kind,     m_axis_tdata[2:0]);
                cmp("report_kind",     e.report_kind,     m_axis_tdata[4:3]);
                cmp("report_number",   e.report_number,   m_axis_tdata[12:5]);
                cmp("field_count",     e.field_count,     m_axis_tdata[44:13]);
                cmp("field_bits",      e.field_bits,      m_axis_tdata[76:45]);
                cmp("field_flags",     e.field_flags,     m_axis_tdata[108:77]);
                cmp("usage_value",     e.usage_value,     m_axis_tdata[140:109]);
                cmp("usage_upper",     e.usage_upper,     m_axis_tdata[172:141]);
                cmp("collection_kind", e.collection_kind, m_axis_tdata[204:173]);
                cmp("status_code",     e.status_code,     m_axis_tdata[208:205]);
                cmp("zero_fill",       32'd0,             32'(m_axis_tdata[215:209]));
                cmp("last_record",     e.last_record,     m_axis_tlast);
            end
        end
    end
endmodule
`default_nettype wire

/* tb/sv/hid_report_descriptor_parser_tb.sv */
// Testbench top: descriptor stimulus, receiver backpressure, watchdog and verdict.
`default_nettype none
module hid_report_descriptor_parser_tb;
    import hidrp_pkg::*;

    // short item header bases (size bits zero): tag<<4 | type<<2
    localparam logic [7:0] H_INPUT    = 8'h80, H_OUTPUT   = 8'h90, H_COLL  = 8'hA0,
                           H_FEATURE  = 8'hB0, H_END_COLL = 8'hC0;
    localparam logic [7:0] H_PAGE     = 8'h04, H_RSIZE    = 8'h74, H_RID   = 8'h84,
                           H_RCOUNT   = 8'h94, H_PUSH     = 8'hA4, H_POP   = 8'hB4;
    localparam logic [7:0] H_USAGE    = 8'h08, H_UMIN     = 8'h18, H_UMAX  = 8'h28,
                           H_DELIM    = 8'hA8;
    localparam logic [7:0] H_RESERVED = 8'h0C;   // type 3
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;

    logic         clk, rst_n;
    logic         s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [215:0] m_axis_tdata;

    int  fail_count, records_pending;
    int  send_idle_pct, recv_idle_pct;
    bit  long_hold_req, long_hold_taken;
    int  hold_cnt, stall_cycles;
    logic [7:0] desc_bytes[$];

    hid_report_descriptor_parser dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    hid_report_descriptor_parser_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .fail_count(fail_count), .records_pending(records_pending)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off so the record path backs
    // up into the byte input.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_cnt = 0;
        long_hold_taken = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_hold_taken)
            begin
                long_hold_taken = 1;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // append one raw byte to the descriptor under construction
    task automatic put_byte(logic [7:0] b);
        desc_bytes = {desc_bytes, b};
    endtask

    // append one short item: size code 3 means four data bytes
    task automatic item(logic [7:0] base, int sc, logic [31:0] data);
        int n;
        n = (sc == 3) ? 4 : sc;
        put_byte(base | 8'(sc));
        for (int i = 0; i < n; i++)
            put_byte(data[8*i +: 8]);
    endtask

    // Sender: entered and left at a falling edge.
    task automatic send_beat(logic [7:0] b, logic fin);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // send the built descriptor, tlast on its final byte
    task automatic send_desc();
        int n;
        n = desc_bytes.size();
        for (int i = 0; i < n; i++)
            send_beat(desc_bytes[i], i == n - 1);
        desc_bytes.delete();
    endtask

    // Mostly well-formed descriptor with random contents; sometimes broken.
    task automatic build_random_desc(int items);
        int nest;
        int pushes;
        nest = 1; pushes = 0;
        item(H_PAGE, $urandom_range(1, 2), $urandom);
        item(H_USAGE, $urandom_range(1, 3), $urandom);
        item(H_COLL, 1, $urandom_range(0, 6));
        repeat (items)
        begin
            case ($urandom_range(0, 17))
                0: item(H_PAGE, $urandom_range(0, 2), $urandom);
                1: item(H_RSIZE, $urandom_range(0, 3), $urandom);
                2: item(H_RCOUNT, $urandom_range(0, 3), $urandom);
                3: item(H_RID, $urandom_range(0, 1), $urandom);
                4, 5: repeat ($urandom_range(1, 5))
                          item(H_USAGE, $urandom_range(1, 3), $urandom);
                6:
                begin
                    item(H_UMIN, $urandom_range(1, 3), $urandom);
                    item(H_UMAX, $urandom_range(1, 3), $urandom);
                end
                7, 8: item(H_INPUT, $urandom_range(0, 3), $urandom);
                9:  item(H_OUTPUT, $urandom_range(0, 2), $urandom);
                10: item(H_FEATURE, $urandom_range(0, 3), $urandom);
                11:
                begin
                    item(H_USAGE, 1, $urandom);
                    item(H_COLL, 1, $urandom);
                    nest++;
                end
                12:
                    if (nest > 1)
                    begin
                        item(H_END_COLL, 0, 0);
                        nest--;
                    end
                13:
                    if (pushes < 6)
                    begin
                        item(H_PUSH, 0, 0);
                        pushes++;
                    end
                    else
                    begin
                        item(H_POP, 0, 0);
                        pushes--;
                    end
                14:
                begin
                    // delimiter set: only the first usage counts
                    item(H_DELIM, 1, 1);
                    repeat ($urandom_range(1, 3))
                        item(H_USAGE, $urandom_range(1, 3), $urandom);
                    item(H_DELIM, 1, 0);
                end
                15:
                begin
                    put_byte(LONG_HDR);
                    put_byte(8'($urandom_range(0, 3)));
                    put_byte(8'($urandom));
                    repeat (desc_bytes[desc_bytes.size()-2])
                        put_byte(8'($urandom));
                end
                16: item(H_RESERVED | (8'($urandom_range(0, 15)) << 4),
                         $urandom_range(0, 3), $urandom);
                default: put_byte(8'($urandom));   // raw noise byte
            endcase
        end
        if (pushes > 0 && $urandom_range(1))
            item(H_POP, 0, 0);
        if ($urandom_range(9) != 0)
            repeat (nest) item(H_END_COLL, 0, 0);
        // occasionally cut the last item short
        if ($urandom_range(9) == 0)
            put_byte(8'h27);
    endtask

    task automatic directed_set();
        // top collection, fields, ranges, padding, long item, all extremes
        item(H_PAGE, 2, 32'hFFFF);
        item(H_USAGE, 1, 32'h02);
        item(H_COLL, 1, 32'h01);
        item(H_RID, 1, 32'hFF);
        item(H_RSIZE, 3, 32'hFFFF_FFFF);
        item(H_RCOUNT, 3, 32'hFFFF_FFFF);
        item(H_UMIN, 1, 0);
        item(H_UMAX, 3, 32'hFFFF_FFFF);
        item(H_INPUT, 1, 32'h02);
        item(H_INPUT, 1, 32'h03);                 // padding: no record
        item(H_USAGE, 3, 32'hA5A5_5A5A);
        item(H_USAGE, 2, 32'h1234);
        item(H_OUTPUT, 3, 32'hFFFF_FFFE);
        item(H_FEATURE, 0, 0);                    // empty range record
        item(H_DELIM, 1, 1);
        item(H_USAGE, 1, 1);
        item(H_USAGE, 0, 0);                      // skipped alternate, not size checked
        item(H_DELIM, 1, 0);
        item(H_DELIM, 1, 7);                      // other delimiter value ignored
        put_byte(LONG_HDR);
        put_byte(8'd2);
        put_byte(8'h11);
        put_byte(8'hAA);
        put_byte(8'hBB);
        item(H_RESERVED, 1, 32'h55);
        item(H_PUSH, 0, 0);
        item(H_POP, 0, 0);
        send_desc();                              // collection left open: unclosed end

        item(H_PAGE, 3, 0); send_desc();          // page with 4 bytes
        item(H_RID, 2, 1); send_desc();           // id with 2 bytes
        item(H_USAGE, 0, 0); send_desc();         // usage without data
        item(H_UMIN, 0, 0); send_desc();
        item(H_UMAX, 0, 0); send_desc();
        item(H_COLL, 1, 0); send_desc();          // no usage for top collection
        item(H_END_COLL, 0, 0); send_desc();      // stray end
        item(H_DELIM, 1, 0); send_desc();         // close while closed
        item(H_DELIM, 1, 1); item(H_DELIM, 1, 1); send_desc();
        item(H_POP, 0, 0); send_desc();           // pop with one entry
        repeat (STACK_DEPTH_DEF) item(H_PUSH, 0, 0);
        send_desc();
        repeat (MAX_USAGES_DEF + 1) item(H_USAGE, 1, 32'h01);
        item(H_INPUT, 1, 0); send_desc();         // bytes after error give nothing
        repeat (MAX_USAGES_DEF) item(H_USAGE, 1, $urandom);
        item(H_FEATURE, 1, 0); send_desc();       // full usage list
        item(H_USAGE, 1, 1); item(H_COLL, 1, 0); item(H_END_COLL, 0, 0);
        send_desc();                              // clean end
        put_byte(8'h26); put_byte(8'hFF);
        send_desc();                              // truncated
        put_byte(LONG_HDR); send_desc();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 0;
        stall_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 38; recv_idle_pct = 49;
        directed_set();

        for (int phase_sel = 0; phase_sel < 3; phase_sel++)
        begin
            send_idle_pct = (phase_sel == 0) ? 38 : (phase_sel == 1) ? 49 : 0;
            recv_idle_pct = (phase_sel == 0) ? 49 : (phase_sel == 1) ? 38 : 0;
            for (int d = 0; d < 6; d++)
            begin
                if (phase_sel == 1 && d == 2)
                    long_hold_req = 1;            // receiver freezes; keep sending
                if (d == 5 && records_pending != 0)
                begin
                    // let every record drain before going on
                    s_axis_tvalid <= 1'b0;
                    while (records_pending != 0)
                        @(negedge clk);
                end
                if ($urandom_range(7) == 0)
                    repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
                else
                    build_random_desc($urandom_range(2, 6));
                send_desc();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (records_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
